// ----- src/fsd_pkg.sv -----
// Shared constants, types and tables for the Fourier series evaluator.
package fsd_pkg;

  localparam int NMOD     = 32;
  localparam int TABLES   = 3;
  localparam int SLOTS    = 32;
  localparam int CELLS    = SLOTS / 2;
  localparam int CNT_W    = $clog2(CELLS);
  localparam int TIDX_W   = (TABLES > 1) ? $clog2(TABLES) : 1;
  // Highest harmonic with a loadable pair; slots past the store read as zero.
  localparam int HARM_TOP = (NMOD / 2 - 1 < CELLS - 1) ? NMOD / 2 - 1 : CELLS - 1;

  localparam int COEF_W  = 32;
  localparam int TSEL_W  = 2;
  localparam int IDX_W   = 5;
  localparam int ANGLE_W = 16;
  localparam int OUT_W   = 48;
  localparam int ACC_W   = 56;
  localparam int SIN_W   = 16;

  localparam int          QUARTER      = 16384;
  localparam logic [31:0] HALF_PI_Q31  = 32'hC90FDAA2;
  localparam int          TAYLOR_STEPS = 7;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t [1:0] coef_pair_t;
  typedef coef_pair_t [TABLES-1:0] cell_data_t;

  // One Taylor iteration in flight: x^2, current term and running sum.
  typedef struct packed {
    logic               valid;
    logic               is_sin;
    logic               neg;
    logic [31:0]        x2;
    logic [31:0]        term;
    logic signed [32:0] sum;
  } taylor_t;

  // Exact divide by 2n(2n+1): q = (v * magic) >> (32 + shift) for v < 2^32.
  typedef struct packed {
    logic [32:0] magic;
    logic [3:0]  shift;
    logic        subtract;
  } taylor_cfg_t;

  localparam taylor_cfg_t TAYLOR_CFG [TAYLOR_STEPS] = '{
    '{magic: 33'(((65'd1 << 35) + 65'd5)   / 65'd6),   shift: 4'd3, subtract: 1'b1},
    '{magic: 33'(((65'd1 << 37) + 65'd19)  / 65'd20),  shift: 4'd5, subtract: 1'b0},
    '{magic: 33'(((65'd1 << 38) + 65'd41)  / 65'd42),  shift: 4'd6, subtract: 1'b1},
    '{magic: 33'(((65'd1 << 39) + 65'd71)  / 65'd72),  shift: 4'd7, subtract: 1'b0},
    '{magic: 33'(((65'd1 << 39) + 65'd109) / 65'd110), shift: 4'd7, subtract: 1'b1},
    '{magic: 33'(((65'd1 << 40) + 65'd155) / 65'd156), shift: 4'd8, subtract: 1'b0},
    '{magic: 33'(((65'd1 << 40) + 65'd209) / 65'd210), shift: 4'd8, subtract: 1'b1}
  };

  typedef struct packed {
    logic                    valid;
    logic                    is_sin;
    logic signed [SIN_W-1:0] value;
  } sine_res_t;

  typedef struct packed {
    logic                    done;
    logic signed [ACC_W-1:0] f0;
    logic signed [ACC_W-1:0] f1;
    logic signed [ACC_W-1:0] f2;
  } mac_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_DELIVER
  } state_t;

  localparam logic signed [ACC_W-1:0] OUT_MAX_ACC =
    {{(ACC_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] OUT_MIN_ACC = ~OUT_MAX_ACC;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    begin
      c = v;
      if (v > OUT_MAX_ACC) c = OUT_MAX_ACC;
      if (v < OUT_MIN_ACC) c = OUT_MIN_ACC;
      return c[OUT_W-1:0];
    end
  endfunction

endpackage

// ----- src/fsd_if.sv -----
// Request and response channel interfaces of the Fourier series evaluator.
interface fsd_req_if import fsd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [TSEL_W-1:0]        table_sel;
  logic [IDX_W-1:0]         coef_index;
  logic signed [COEF_W-1:0] coef_value;
  logic [ANGLE_W-1:0]       angle;

  modport source (output valid, req_type, table_sel, coef_index, coef_value, angle,
                  input ready);
  modport sink (input valid, req_type, table_sel, coef_index, coef_value, angle,
                output ready);
endinterface

interface fsd_rsp_if import fsd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] series_value;
  logic signed [OUT_W-1:0] first_derivative;
  logic signed [OUT_W-1:0] second_derivative;

  modport source (output valid, series_value, first_derivative, second_derivative,
                  input ready);
  modport sink (input valid, series_value, first_derivative, second_derivative,
                output ready);
endinterface

// ----- src/fsd_coef_cell.sv -----
// Coefficient ring cell: one slot pair of every table, passed on when the ring turns.
module fsd_coef_cell import fsd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift_en,
  input  cell_data_t        shift_in,
  input  logic              wr_en,
  input  logic [TIDX_W-1:0] wr_table,
  input  logic              wr_word,
  input  coef_t             wr_data,
  output cell_data_t        data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      data <= '0;
    end else if (shift_en) begin
      data <= shift_in;
    end else if (wr_en) begin
      data[wr_table][wr_word] <= wr_data;
    end
  end

endmodule

// ----- src/fsd_taylor_cell.sv -----
// Taylor cell: term *= x^2, exact divide by 2n(2n+1), add or subtract into the sum.
module fsd_taylor_cell import fsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  taylor_cfg_t cfg,
  input  taylor_t     din,
  output taylor_t     dout
);

  taylor_t     a_q;
  logic [63:0] a_prod;
  taylor_t     b_q;
  logic [64:0] b_prod;
  logic [31:0] n_val;
  logic [6:0]  amt;
  logic [31:0] q;
  taylor_t     a_next;
  taylor_t     b_next;
  taylor_t     dout_next;

  assign n_val = a_prod[61:30];
  assign amt   = 7'd32 + {3'b000, cfg.shift};
  assign q     = 32'(b_prod >> amt);

  always_comb begin
    a_next          = din;
    a_next.valid    = din.valid && !rst;
    b_next          = a_q;
    b_next.valid    = a_q.valid && !rst;
    dout_next       = b_q;
    dout_next.valid = b_q.valid && !rst;
    dout_next.term  = q;
    dout_next.sum   = cfg.subtract ? b_q.sum - $signed({1'b0, q})
                                   : b_q.sum + $signed({1'b0, q});
  end

  always_ff @(posedge clk) begin
    a_q    <= a_next;
    a_prod <= din.term * din.x2;
    b_q    <= b_next;
    b_prod <= n_val * cfg.magic;
    dout   <= dout_next;
  end

endmodule

// ----- src/fsd_sine.sv -----
// Pipelined Q1.15 sine of a 16-bit phase: quarter-wave fold, Taylor cell chain, round.
module fsd_sine import fsd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_is_sin,
  input  logic [ANGLE_W-1:0] in_phase,
  output sine_res_t          res
);

  logic [1:0]  quad;
  logic [13:0] r;
  logic [14:0] idx;

  logic        f0_valid, f0_is_sin, f0_neg;
  logic [46:0] f0_prod;
  logic [47:0] xs;
  logic [31:0] x;

  logic        f1_valid, f1_is_sin, f1_neg;
  logic [31:0] f1_x;
  logic [63:0] f1_xx;
  logic [63:0] xxr;

  taylor_t chain [TAYLOR_STEPS+1];

  logic signed [32:0] s_fin;
  logic [31:0]        s_pos;
  logic [33:0]        rnd;
  logic [18:0]        v_raw;
  logic [SIN_W-1:0]   v_clip;

  assign quad = in_phase[15:14];
  assign r    = in_phase[13:0];
  assign idx  = quad[0] ? 15'(QUARTER) - {1'b0, r} : {1'b0, r};

  assign xs  = {1'b0, f0_prod} + 48'd16384;
  assign x   = xs[46:15];
  assign xxr = f1_xx + (64'd1 << 29);

  always_ff @(posedge clk) begin
    f0_valid  <= in_valid && !rst;
    f0_is_sin <= in_is_sin;
    f0_neg    <= quad[1];
    f0_prod   <= idx * HALF_PI_Q31;
    f1_valid  <= f0_valid && !rst;
    f1_is_sin <= f0_is_sin;
    f1_neg    <= f0_neg;
    f1_x      <= x;
    f1_xx     <= x * x;
    chain[0].valid  <= f1_valid && !rst;
    chain[0].is_sin <= f1_is_sin;
    chain[0].neg    <= f1_neg;
    chain[0].x2     <= xxr[61:30];
    chain[0].term   <= f1_x;
    chain[0].sum    <= $signed({1'b0, f1_x});
  end

  for (genvar n = 0; n < TAYLOR_STEPS; n++) begin : g_step
    fsd_taylor_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .cfg  (TAYLOR_CFG[n]),
      .din  (chain[n]),
      .dout (chain[n+1])
    );
  end

  // Clamp at zero, round to Q1.15, clip to full scale, restore the sign.
  assign s_fin  = chain[TAYLOR_STEPS].sum;
  assign s_pos  = s_fin[32] ? 32'd0 : s_fin[31:0];
  assign rnd    = {2'b00, s_pos} + 34'd16384;
  assign v_raw  = rnd[33:15];
  assign v_clip = (v_raw > 19'd32767) ? 16'd32767 : v_raw[SIN_W-1:0];

  always_ff @(posedge clk) begin
    res.is_sin <= chain[TAYLOR_STEPS].is_sin;
    res.value  <= chain[TAYLOR_STEPS].neg ? -$signed(v_clip) : $signed(v_clip);
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= chain[TAYLOR_STEPS].valid;
    end
  end

endmodule

// ----- src/fsd_mac.sv -----
// Harmonic multiply-accumulate: per pair, rounded v and w, scaled by k and k^2, summed.
module fsd_mac import fsd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  sine_res_t res,
  input  coef_t     a,
  input  coef_t     b,
  output logic      rotate,
  output mac_stat_t stat
);

  logic [CNT_W-1:0]        j;
  logic signed [SIN_W-1:0] c_q;
  logic                    use_term;

  logic                      m1_valid, m1_last;
  logic signed [47:0]        m1_ac, m1_bs, m1_bc, m1_as;
  coef_t                     m1_base;
  logic [CNT_W-1:0]          m1_k;
  logic [2*CNT_W-1:0]        m1_ksq;

  logic signed [49:0] sv, sw;

  logic                      m2_valid, m2_last;
  logic signed [34:0]        m2_v, m2_w;
  coef_t                     m2_base;
  logic [CNT_W-1:0]          m2_k;
  logic [2*CNT_W-1:0]        m2_ksq;

  logic                         m3_valid, m3_last;
  logic signed [34:0]           m3_v;
  logic signed [CNT_W+35:0]     m3_kw;
  logic signed [2*CNT_W+35:0]   m3_kkv;
  coef_t                        m3_base;

  assign rotate   = res.valid && res.is_sin;
  assign use_term = (j >= CNT_W'(2)) && (j <= CNT_W'(HARM_TOP));

  // round half up to Q16.16
  assign sv = m1_ac + m1_bs + 50'sd16384;
  assign sw = m1_bc - m1_as + 50'sd16384;

  always_ff @(posedge clk) begin
    if (res.valid && !res.is_sin) begin
      c_q <= res.value;
    end
    m1_ac   <= use_term ? a * c_q       : 48'sd0;
    m1_bs   <= use_term ? b * res.value : 48'sd0;
    m1_bc   <= use_term ? b * c_q       : 48'sd0;
    m1_as   <= use_term ? a * res.value : 48'sd0;
    m1_base <= (j == '0) ? a : '0;
    m1_k    <= j;
    m1_ksq  <= j * j;
    m1_last <= (j == CNT_W'(CELLS - 1));

    m2_v    <= sv[49:15];
    m2_w    <= sw[49:15];
    m2_base <= m1_base;
    m2_k    <= m1_k;
    m2_ksq  <= m1_ksq;
    m2_last <= m1_last;

    m3_v    <= m2_v;
    m3_kw   <= $signed({1'b0, m2_k}) * m2_w;
    m3_kkv  <= $signed({1'b0, m2_ksq}) * m2_v;
    m3_base <= m2_base;
    m3_last <= m2_last;

    if (rst) begin
      j         <= '0;
      m1_valid  <= 1'b0;
      m2_valid  <= 1'b0;
      m3_valid  <= 1'b0;
      stat.done <= 1'b0;
      stat.f0   <= '0;
      stat.f1   <= '0;
      stat.f2   <= '0;
    end else begin
      m1_valid  <= rotate;
      m2_valid  <= m1_valid;
      m3_valid  <= m2_valid;
      stat.done <= m3_valid && m3_last;
      if (start) begin
        j       <= '0;
        stat.f0 <= '0;
        stat.f1 <= '0;
        stat.f2 <= '0;
      end else begin
        if (rotate) begin
          j <= (j == CNT_W'(CELLS - 1)) ? '0 : j + 1'b1;
        end
        if (m3_valid) begin
          stat.f0 <= stat.f0 + ACC_W'(m3_base) + ACC_W'(m3_v);
          stat.f1 <= stat.f1 + ACC_W'(m3_kw);
          stat.f2 <= stat.f2 - ACC_W'(m3_kkv);
        end
      end
    end
  end

endmodule

// ----- src/fourier_series_with_derivatives_unit.sv -----
// Top level of the truncated Fourier series evaluator with angular derivatives.
//
// Use: one request channel (req) and one response channel (rsp), both valid/ready.
// A request transaction with req_type = load writes coef_value into slot coef_index
// of table table_sel; it produces no response. A load to a
// table past the last one is dropped. A request with req_type = evaluate computes
// the series, its first and its second angular derivative at the 16-bit phase
// angle, and later produces exactly one response transaction.
// Flow of an evaluate after its acceptance: the cosine and sine phases of the
// 16 slot pairs are issued, the last sine leaves the 25-stage sine pipeline
// (quarter-wave fold, 7 Taylor cells, rounding), then 4 multiply-accumulate
// stages follow, the control reaches the deliver step, and the result is
// saturated into the output register, which raises rsp.valid.
// One evaluate is in flight at a time; the next is taken in the same cycle
// in which the response appears.
// The coefficients live in a ring of 16 cells that turns once per evaluate and
// ends where it began. Reset (rst, synchronous) clears all tables to zero and
// empties the pipelines. A new request is taken while a response still waits;
// when rsp.ready is low the finished result is held in place until it is taken.
module fourier_series_with_derivatives_unit import fsd_pkg::*; (
  input logic       clk,
  input logic       rst,
  fsd_req_if.sink   req,
  fsd_rsp_if.source rsp
);

  state_t state, state_next;

  logic [CNT_W:0]      cnt;
  logic [ANGLE_W-1:0]  ph;
  logic [ANGLE_W-1:0]  angle_q;
  logic [TSEL_W-1:0]   tsel_q;

  logic req_acc, load_acc, eval_acc;
  logic issue;
  logic out_load;
  logic rotate;
  logic tsel_ok;

  cell_data_t cell_q [CELLS];
  coef_t      head_a, head_b;

  sine_res_t sres;
  mac_stat_t mac_stat;

  assign req_acc  = req.valid && req.ready;
  assign load_acc = req_acc && (req.req_type == REQ_LOAD) && (req.table_sel < TABLES);
  assign eval_acc = req_acc && (req.req_type == REQ_EVAL);

  // Coefficient ring: cell i takes from cell i+1 when the ring turns, so cell 0
  // presents pair j at the j-th turn.
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    fsd_coef_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift_en (rotate),
      .shift_in (cell_q[(i + 1) % CELLS]),
      .wr_en    (load_acc && (req.coef_index[IDX_W-1:1] == CNT_W'(i))),
      .wr_table (req.table_sel[TIDX_W-1:0]),
      .wr_word  (req.coef_index[0]),
      .wr_data  (req.coef_value),
      .data     (cell_q[i])
    );
  end

  // Unknown table reads as all-zero coefficients, giving an all-zero result.
  assign tsel_ok = (tsel_q < TABLES);
  assign head_a  = tsel_ok ? cell_q[0][tsel_q[TIDX_W-1:0]][0] : '0;
  assign head_b  = tsel_ok ? cell_q[0][tsel_q[TIDX_W-1:0]][1] : '0;

  // Even count issues the cosine phase, odd count the sine phase of harmonic k.
  fsd_sine u_sine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (issue),
    .in_is_sin (cnt[0]),
    .in_phase  (cnt[0] ? ph : ph + ANGLE_W'(QUARTER)),
    .res       (sres)
  );

  fsd_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .start  (eval_acc),
    .res    (sres),
    .a      (head_a),
    .b      (head_b),
    .rotate (rotate),
    .stat   (mac_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    issue      = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (eval_acc) state_next = ST_ISSUE;
      end
      ST_ISSUE: begin
        issue = 1'b1;
        if (cnt == {(CNT_W + 1){1'b1}}) state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (mac_stat.done) state_next = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (!rsp.valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Issue counter and harmonic phase k*angle, kept by repeated addition.
  always_ff @(posedge clk) begin
    if (eval_acc) begin
      angle_q <= req.angle;
      tsel_q  <= req.table_sel;
    end
    if (rst) begin
      cnt <= '0;
      ph  <= '0;
    end else if (eval_acc) begin
      cnt <= '0;
      ph  <= '0;
    end else if (issue) begin
      cnt <= cnt + 1'b1;
      if (cnt[0]) ph <= ph + angle_q;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.series_value      <= sat_out(mac_stat.f0);
      rsp.first_derivative  <= sat_out(mac_stat.f1);
      rsp.second_derivative <= sat_out(mac_stat.f2);
    end
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // The ring only turns during an evaluate; a turn while loads are taken
  // would misplace coefficients.
  a_no_turn_in_idle: assert property (@(posedge clk) disable iff (rst)
    rotate |-> (state != ST_IDLE))
    else $error("coefficient ring turned while idle");

  // The last harmonic completes only after all phases were issued.
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mac_stat.done |-> (state == ST_WAIT))
    else $error("accumulation finished outside the wait state");

  // A response appears only from the deliver step.
  a_rsp_from_deliver: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == ST_DELIVER))
    else $error("response raised without a finished evaluate");

  // No sine result may still be in flight when a new evaluate starts.
  a_pipe_empty_at_start: assert property (@(posedge clk) disable iff (rst)
    eval_acc |-> !sres.valid)
    else $error("sine pipeline busy at start of evaluate");

endmodule

// ----- sim/fsd_series_checker.sv -----
// Scoreboard for the Fourier series evaluator: predicts and checks every response.
module fsd_series_checker import fsd_pkg::*; (
  input  logic clk,
  input  logic rst,
  fsd_req_if   req,
  fsd_rsp_if   rsp,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PRINTS = 100;

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic signed [OUT_W-1:0] slope;
    logic signed [OUT_W-1:0] curve;
  } series_t;

  int      sine_quarter [0:QUARTER];
  longint  coef_store [TABLES][SLOTS];
  series_t series_q [$];
  series_t oldest;

  // Quarter-wave sine in Q1.15, odd Taylor series on a Q30 argument.
  function automatic void build_sine_quarter();
    longint unsigned x, x2, term;
    longint sum, v;
    for (int i = 0; i <= QUARTER; i++) begin
      x = (64'(i) * 64'(HALF_PI_Q31) + 64'd16384) >> 15;
      x2 = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= TAYLOR_STEPS; n++) begin
        term = ((term * x2) >> 30) / 64'(2 * n * (2 * n + 1));
        if (n % 2 == 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      v = (sum + 64'sd16384) >>> 15;
      if (v > 32767) v = 32767;
      sine_quarter[i] = int'(v);
    end
  endfunction

  function automatic longint sine_q15(logic [ANGLE_W-1:0] phase);
    longint mag;
    if (phase[14]) mag = sine_quarter[QUARTER - int'(phase[13:0])];
    else mag = sine_quarter[int'(phase[13:0])];
    return phase[15] ? -mag : mag;
  endfunction

  // Q16.16 x Q1.15 back to Q16.16, half up.
  function automatic longint round_q15(longint x);
    return (x + 64'sd16384) >>> 15;
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp_out(longint x);
    longint top;
    top = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
    if (x > top) x = top;
    else if (x < -top - 64'sd1) x = -top - 64'sd1;
    return x[OUT_W-1:0];
  endfunction

  function automatic series_t predict_series(logic [TSEL_W-1:0] tsel,
                                             logic [ANGLE_W-1:0] ang);
    series_t r;
    longint f0, f1, f2, a, b, c, s, v, w;
    logic [ANGLE_W-1:0] ph;
    f0 = 0;
    f1 = 0;
    f2 = 0;
    if (int'(tsel) < TABLES) begin
      f0 = coef_store[tsel][0];
      for (int k = 2; k + 1 <= NMOD / 2; k++) begin
        ph = ANGLE_W'(k * int'(ang));
        a = (2 * k < SLOTS) ? coef_store[tsel][2 * k] : 0;
        b = (2 * k + 1 < SLOTS) ? coef_store[tsel][2 * k + 1] : 0;
        c = sine_q15(ph + ANGLE_W'(QUARTER));
        s = sine_q15(ph);
        v = round_q15(a * c + b * s);
        w = round_q15(b * c - a * s);
        f0 += v;
        f1 += longint'(k) * w;
        f2 -= longint'(k * k) * v;
      end
    end
    r.value = clamp_out(f0);
    r.slope = clamp_out(f1);
    r.curve = clamp_out(f2);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [OUT_W-1:0] got,
                                 logic [OUT_W-1:0] want);
    if (errors < MAX_PRINTS)
      $display("%0t ns mismatch: %s got %h expected %h", $time, what, got, want);
    errors++;
  endtask

  initial build_sine_quarter();

  always @(posedge clk) begin
    if (rst) begin
      series_q.delete();
      foreach (coef_store[t, s]) coef_store[t][s] = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (series_q.size() == 0) begin
          report_mismatch("response with none outstanding", rsp.series_value, '0);
        end else begin
          oldest = series_q.pop_front();
          if (rsp.series_value !== oldest.value)
            report_mismatch("series_value", rsp.series_value, oldest.value);
          if (rsp.first_derivative !== oldest.slope)
            report_mismatch("first_derivative", rsp.first_derivative, oldest.slope);
          if (rsp.second_derivative !== oldest.curve)
            report_mismatch("second_derivative", rsp.second_derivative, oldest.curve);
        end
      end
      if (req.valid && req.ready) begin
        if (req.req_type == REQ_EVAL)
          series_q.push_back(predict_series(req.table_sel, req.angle));
        else if (int'(req.table_sel) < TABLES)
          coef_store[req.table_sel][req.coef_index] = longint'(req.coef_value);
      end
    end
    pending <= series_q.size();
  end

endmodule

// ----- sim/fourier_series_with_derivatives_unit_tb.sv -----
// Testbench top: clock, reset, request and response traffic, and the verdict.
module fourier_series_with_derivatives_unit_tb import fsd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Random transactions counted toward the run; dropped loads do not count.
  localparam int RANDOM_ITEMS = 1225;
  // Long response back-pressure, long enough to fill the block and stall req.
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AT      = 300;
  // Point where the sender stops until every evaluate has been answered.
  localparam int DRAIN_AT     = 700;
  // The tail outlasts one evaluate with margin.
  localparam int TAIL_CYCLES  = 100;
  // Worst idle stretch: the hold plus one evaluate plus gaps, several times over.
  localparam int IDLE_LIMIT   = 3000;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  bit   tx_quiet;
  bit   rx_quiet;
  bit   rx_hold;

  fsd_req_if req_ch();
  fsd_rsp_if rsp_ch();

  fourier_series_with_derivatives_unit dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Watches both channels, keeps its own coefficient tables, checks responses.
  fsd_series_checker series_check (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .errors(errors),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Coefficients: full-range noise half the time, with the extremes and small values
  // (within +-2.0) mixed in so that sums stay readable in a waveform too.
  function automatic logic [COEF_W-1:0] draw_coef();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return COEF_W'($urandom_range(0, 32'h0003_FFFF)) - 32'h0002_0000;
      default: return $urandom();
    endcase
  endfunction

  // Angles: quadrant boundaries and the last phase now and then.
  function automatic logic [ANGLE_W-1:0] draw_angle();
    case ($urandom_range(0, 11))
      0: return 16'h0000;
      1: return 16'h4000;
      2: return 16'h8000;
      3: return 16'hC000;
      4: return 16'hFFFF;
      default: return ANGLE_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // Table select past the last table shows up now and then.
  function automatic logic [TSEL_W-1:0] draw_table();
    if ($urandom_range(0, 15) == 0) return TSEL_W'(TABLES);
    return TSEL_W'($urandom_range(0, TABLES - 1));
  endfunction

  // One request transaction. valid stays high across back-to-back transactions
  // so that it never gets two assignments in one time step.
  task automatic send_req(input logic rt, input logic [TSEL_W-1:0] ts,
                          input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] val,
                          input logic [ANGLE_W-1:0] ang);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= rt;
    req_ch.table_sel  <= ts;
    req_ch.coef_index <= idx;
    req_ch.coef_value <= val;
    req_ch.angle      <= ang;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic send_load(input logic [TSEL_W-1:0] ts, input logic [IDX_W-1:0] idx,
                           input logic [COEF_W-1:0] val);
    send_req(REQ_LOAD, ts, idx, val, ANGLE_W'($urandom()));
  endtask

  // Coefficient fields carry junk on an evaluate; the block must ignore them.
  task automatic send_eval(input logic [TSEL_W-1:0] ts, input logic [ANGLE_W-1:0] ang);
    send_req(REQ_EVAL, ts, IDX_W'($urandom()), $urandom(), ang);
  endtask

  // Stop offering and wait for every outstanding response. The first edge lets
  // the checker count a transaction accepted at the current one.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int                issued;
    bit                counted;
    logic [TSEL_W-1:0] tsel;
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= REQ_LOAD;
    req_ch.table_sel  <= '0;
    req_ch.coef_index <= '0;
    req_ch.coef_value <= '0;
    req_ch.angle      <= '0;
    tx_quiet = 1'b0;
    rx_hold  = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Tables are all zero after reset.
    send_eval(2'd0, 16'h0000);
    send_eval(2'd3, 16'hFFFF);                  // table past the end: zeros
    send_load(2'd0, 5'd0, 32'h7FFF_FFFF);       // constant term at max
    send_load(2'd0, 5'd4, 32'h8000_0000);       // lowest harmonic, cosine at min
    send_load(2'd0, 5'd5, 32'h7FFF_FFFF);       // lowest harmonic, sine at max
    send_load(2'd0, 5'd30, 32'h7FFF_FFFF);      // top harmonic
    send_load(2'd0, 5'd31, 32'h8000_0000);
    send_load(2'd0, 5'd1, 32'h1234_5678);       // stored but never read
    send_load(2'd0, 5'd3, 32'h8000_0000);       // stored but never read
    send_eval(2'd0, 16'h0000);
    send_eval(2'd0, 16'h4000);
    send_eval(2'd0, 16'h8000);
    send_eval(2'd0, 16'hFFFF);
    send_load(2'd3, 5'd0, 32'h7FFF_FFFF);       // dropped load
    send_eval(2'd3, 16'h1234);
    send_load(2'd1, 5'd31, 32'h0001_0000);
    send_load(2'd2, 5'd2, 32'hFFFF_FFFF);       // unused slot in table 2
    send_load(2'd2, 5'd6, 32'hFFFF_FFFF);
    send_eval(2'd1, 16'h2AAA);
    send_eval(2'd2, 16'h0001);
    send_load(2'd2, 5'd0, 32'h8000_0000);
    send_eval(2'd2, 16'hC000);
    send_eval(2'd0, 16'h5555);

    // Random part: loads and evaluates mixed, every slot of every table
    // reachable, with stretches where the sender never idles.
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      if ($urandom_range(0, 59) == 0) tx_quiet = !tx_quiet;
      tsel = draw_table();
      if ($urandom_range(0, 99) < 55) begin
        send_load(tsel, IDX_W'($urandom_range(0, SLOTS - 1)), draw_coef());
        counted = (int'(tsel) < TABLES);
      end else begin
        send_eval(tsel, draw_angle());
        counted = 1'b1;
      end
      if (counted) begin
        issued++;
        if (issued == HOLD_AT) rx_hold = 1'b1;
        if (issued == DRAIN_AT) wait_drained();
      end
    end

    // Let the last evaluate come out, then watch for stray responses.
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // Response side: random ready gaps per transaction, quiet stretches, and one
  // long hold-off once the sender asks for it.
  initial begin : response_sink
    int gap;
    bit held;
    held     = 1'b0;
    rx_quiet = 1'b0;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold && !held) begin
        held = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
      gap = rx_quiet ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  // Watchdog: cycles with no transaction on either channel.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
src/fsd_pkg.sv
src/fsd_if.sv
src/fsd_coef_cell.sv
src/fsd_taylor_cell.sv
src/fsd_sine.sv
src/fsd_mac.sv
src/fourier_series_with_derivatives_unit.sv
sim/fsd_series_checker.sv
sim/fourier_series_with_derivatives_unit_tb.sv
